// ===== rtl/rop_pkg.sv =====
package rop_pkg;

  localparam logic signed [31:0] T_INF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic       in_rdy;
    logic       q_mul;
    logic       q_wr;
    logic       r_mul;
    logic       r_acc;
    logic       h_mul;
    logic       h_wr;
    logic       div_start;
    logic       div_hi;
    logic       t0_wr;
    logic       t1_wr;
    logic       slab_upd;
    logic       commit;
    logic       emit;
    logic [3:0] k;
    logic [2:0] j;
    logic [1:0] r;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic in_acc;
    logic in_movable;
    logic in_last;
    logic last;
    logic d_zero;
    logic par_miss;
    logic div_done;
    logic slab_miss;
    logic better;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(T_INF)) return T_INF;
    if (v < 64'(T_MIN)) return T_MIN;
    return v[31:0];
  endfunction

  // round half up from Q32 to Q16
  function automatic logic signed [47:0] rnd64(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + 64'sd32768;
    return s[63:16];
  endfunction

endpackage

// ===== rtl/rop_in_if.sv =====
interface rop_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [17:0] rot_x;
  logic signed [17:0] rot_y;
  logic signed [17:0] rot_z;
  logic signed [17:0] rot_w;
  logic [30:0]        size_x;
  logic [30:0]        size_y;
  logic [30:0]        size_z;
  logic               movable;
  logic               last_body;
  modport source (output valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w,
                  size_x, size_y, size_z, movable, last_body, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w,
                size_x, size_y, size_z, movable, last_body, output ready);
endinterface

// ===== rtl/rop_out_if.sv =====
interface rop_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [9:0]         body_index;
  logic [30:0]        hit_distance;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic signed [31:0] local_z;
  modport source (output valid, hit, body_index, hit_distance, local_x, local_y, local_z,
                  input ready);
  modport sink (input valid, hit, body_index, hit_distance, local_x, local_y, local_z,
                output ready);
endinterface

// ===== rtl/rop_cfg_if.sv =====
interface rop_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rop_div.sv =====
module rop_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [48:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import rop_pkg::*;

  localparam int NB = 48;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [47:0] dq;
  logic [31:0] dabs;
  logic        neg;
  logic [32:0] sh;
  logic [32:0] trial;
  logic signed [48:0] nabs;
  logic signed [48:0] qs;

  assign nabs  = num[48] ? -num : num;
  assign sh    = {rem, dq[NB-1]};
  assign trial = sh - {1'b0, dabs};
  assign qs    = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign quo   = sat32(64'(qs));

  // restoring divide on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dq   <= nabs[47:0];
        dabs <= den[31] ? 32'(-den) : den;
        neg  <= num[48] ^ den[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          dq  <= {dq[NB-2:0], 1'b1};
        end else begin
          rem <= sh[31:0];
          dq  <= {dq[NB-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/rop_dp.sv =====
module rop_dp #(
  parameter int MAX_BODIES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  rop_in_if.sink         in_ch,
  rop_out_if.source      out_ch,
  rop_cfg_if.sink        cfg_ch,
  input  rop_pkg::cmd_t  cmd,
  output rop_pkg::sts_t  sts
);
  import rop_pkg::*;

  localparam int CW = (MAX_BODIES > 2) ? $clog2(MAX_BODIES) : 1;
  localparam logic signed [39:0] Q_ONE = 40'sh01_0000_0000;

  // configuration
  logic signed [31:0] origin [3];
  logic signed [31:0] dir [3];

  // current item
  logic signed [31:0] pos [3];
  logic signed [17:0] q [4];
  logic [29:0]        half [3];
  logic               last;
  logic [9:0]         cur_idx;
  logic [CW-1:0]      counter;
  logic [CW+9:0]      cnt_ext;

  // arithmetic
  logic signed [35:0] pq [9];
  logic signed [39:0] e [9];
  logic signed [23:0] m [9];
  logic signed [31:0] vec [6];
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_sum;
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [64:0] mfull;
  logic signed [32:0] rel [3];
  logic [1:0]         qa, qb, col;

  // slab
  logic [2:0]         didx;
  logic signed [31:0] o, d;
  logic signed [32:0] hs, bsel, diff;
  logic signed [48:0] num;
  logic               div_done;
  logic signed [31:0] quo;
  logic signed [31:0] t0, t1, enter, exit_t, lo, hi, ne, nx;
  logic signed [31:0] loc [3];

  // query state
  logic signed [31:0] best_dist;
  logic [9:0]         best_body;
  logic signed [31:0] best_loc [3];
  logic               any_hit;
  logic               out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.in_rdy;
  assign cnt_ext      = {10'd0, counter};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        dir[i]    <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ORIGIN_X: origin[0] <= cfg_ch.data;
        REG_ORIGIN_Y: origin[1] <= cfg_ch.data;
        REG_ORIGIN_Z: origin[2] <= cfg_ch.data;
        REG_DIR_X:    dir[0]    <= cfg_ch.data;
        REG_DIR_Y:    dir[1]    <= cfg_ch.data;
        REG_DIR_Z:    dir[2]    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // rotation matrix from the registered quaternion products
  always_comb begin
    e[0] = Q_ONE - ((40'(pq[1]) + 40'(pq[2])) <<< 1);
    e[1] = (40'(pq[3]) - 40'(pq[8])) <<< 1;
    e[2] = (40'(pq[4]) + 40'(pq[7])) <<< 1;
    e[3] = (40'(pq[3]) + 40'(pq[8])) <<< 1;
    e[4] = Q_ONE - ((40'(pq[0]) + 40'(pq[2])) <<< 1);
    e[5] = (40'(pq[5]) - 40'(pq[6])) <<< 1;
    e[6] = (40'(pq[4]) - 40'(pq[7])) <<< 1;
    e[7] = (40'(pq[5]) + 40'(pq[6])) <<< 1;
    e[8] = Q_ONE - ((40'(pq[0]) + 40'(pq[1])) <<< 1);
    for (int i = 0; i < 9; i++) m[i] = 24'((e[i] + 40'sd32768) >>> 16);
    for (int i = 0; i < 3; i++) rel[i] = 33'(origin[i]) - 33'(pos[i]);
  end

  // shared multiplier operand select
  always_comb begin
    qa  = 2'd0;
    qb  = 2'd0;
    col = 2'd0;
    case (cmd.k)
      4'd0: begin qa = 2'd0; qb = 2'd0; end
      4'd1: begin qa = 2'd1; qb = 2'd1; end
      4'd2: begin qa = 2'd2; qb = 2'd2; end
      4'd3: begin qa = 2'd0; qb = 2'd1; end
      4'd4: begin qa = 2'd0; qb = 2'd2; end
      4'd5: begin qa = 2'd1; qb = 2'd2; end
      4'd6: begin qa = 2'd0; qb = 2'd3; end
      4'd7: begin qa = 2'd1; qb = 2'd3; end
      default: begin qa = 2'd2; qb = 2'd3; end
    endcase
    case (cmd.j)
      3'd0, 3'd3: col = 2'd0;
      3'd1, 3'd4: col = 2'd1;
      default:    col = 2'd2;
    endcase
    ma = '0;
    mb = '0;
    if (cmd.q_mul) begin
      ma = 33'(q[qa]);
      mb = 32'(q[qb]);
    end else if (cmd.r_mul) begin
      ma = (cmd.j < 3'd3) ? rel[cmd.r] : 33'(dir[cmd.r]);
      mb = 32'(m[4'(cmd.r) * 4'd3 + 4'(col)]);
    end else if (cmd.h_mul) begin
      ma = 33'(d);
      mb = enter;
    end
    mfull = ma * mb;
  end

  assign acc_sum = ((cmd.r == 2'd0) ? 64'sd0 : acc) + prod;

  // per-axis slab signals
  assign didx = {1'b0, cmd.axis} + 3'd3;
  assign o    = vec[{1'b0, cmd.axis}];
  assign d    = vec[didx];
  assign hs   = $signed({3'b000, half[cmd.axis]});
  assign bsel = cmd.div_hi ? hs : -hs;
  assign diff = bsel - 33'(o);
  assign num  = {diff, 16'd0};

  rop_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (d),
    .done  (div_done),
    .quo   (quo)
  );

  assign lo = (t0 > t1) ? t1 : t0;
  assign hi = (t0 > t1) ? t0 : t1;
  assign ne = (lo > enter) ? lo : enter;
  assign nx = (hi < exit_t) ? hi : exit_t;

  assign sts.in_acc     = in_ch.valid & cmd.in_rdy;
  assign sts.in_movable = in_ch.movable;
  assign sts.in_last    = in_ch.last_body;
  assign sts.last       = last;
  assign sts.d_zero     = (d == 32'sd0);
  assign sts.par_miss   = (33'(o) < -hs) || (33'(o) > hs);
  assign sts.div_done   = div_done;
  assign sts.slab_miss  = (ne > nx);
  assign sts.better     = (enter < best_dist);
  assign sts.out_free   = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (sts.in_acc) begin
      pos[0]  <= in_ch.pos_x;
      pos[1]  <= in_ch.pos_y;
      pos[2]  <= in_ch.pos_z;
      q[0]    <= in_ch.rot_x;
      q[1]    <= in_ch.rot_y;
      q[2]    <= in_ch.rot_z;
      q[3]    <= in_ch.rot_w;
      half[0] <= in_ch.size_x[30:1];
      half[1] <= in_ch.size_y[30:1];
      half[2] <= in_ch.size_z[30:1];
      cur_idx <= cnt_ext[9:0];
      enter   <= '0;
      exit_t  <= T_INF;
    end
    if (cmd.q_mul || cmd.r_mul || cmd.h_mul) prod <= mfull[63:0];
    if (cmd.q_wr) pq[cmd.k] <= prod[35:0];
    if (cmd.r_acc) begin
      acc <= acc_sum;
      if (cmd.r == 2'd2) vec[cmd.j] <= sat32(64'(rnd64(acc_sum)));
    end
    if (cmd.t0_wr) t0 <= quo;
    if (cmd.t1_wr) t1 <= quo;
    if (cmd.slab_upd) begin
      enter  <= ne;
      exit_t <= nx;
    end
    if (cmd.h_wr) loc[cmd.axis] <= sat32(64'(o) + 64'(rnd64(prod)));
  end

  // query state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      last      <= 1'b0;
      counter   <= '0;
      best_dist <= T_INF;
      best_body <= '0;
      any_hit   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) best_loc[i] <= '0;
    end else begin
      if (sts.in_acc) begin
        last    <= in_ch.last_body;
        counter <= (counter == CW'(MAX_BODIES - 1)) ? '0 : counter + CW'(1);
      end
      if (cmd.commit) begin
        best_dist <= enter;
        best_body <= cur_idx;
        any_hit   <= 1'b1;
        for (int i = 0; i < 3; i++) best_loc[i] <= loc[i];
      end
      if (cmd.emit) begin
        out_valid           <= 1'b1;
        out_ch.hit          <= any_hit;
        out_ch.body_index   <= best_body;
        out_ch.hit_distance <= best_dist[30:0];
        out_ch.local_x      <= best_loc[0];
        out_ch.local_y      <= best_loc[1];
        out_ch.local_z      <= best_loc[2];
        best_dist <= T_INF;
        best_body <= '0;
        any_hit   <= 1'b0;
        counter   <= '0;
        for (int i = 0; i < 3; i++) best_loc[i] <= '0;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;
endmodule

// ===== rtl/rop_ctrl.sv =====
module rop_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rop_pkg::sts_t sts,
  output rop_pkg::cmd_t cmd
);
  import rop_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_QMUL   = 15'b000000000000010,
    S_QACC   = 15'b000000000000100,
    S_RMUL   = 15'b000000000001000,
    S_RACC   = 15'b000000000010000,
    S_AXIS   = 15'b000000000100000,
    S_DIV0   = 15'b000000001000000,
    S_DIV1   = 15'b000000010000000,
    S_SLAB   = 15'b000000100000000,
    S_DECIDE = 15'b000001000000000,
    S_HMUL   = 15'b000010000000000,
    S_HACC   = 15'b000100000000000,
    S_COMMIT = 15'b001000000000000,
    S_ENDQ   = 15'b010000000000000,
    S_FINISH = 15'b100000000000000
  } state_t;

  state_t     state;
  logic [3:0] k;
  logic [2:0] j;
  logic [1:0] r;
  logic [1:0] axis;

  always_comb begin
    cmd      = '0;
    cmd.k    = k;
    cmd.j    = j;
    cmd.r    = r;
    cmd.axis = axis;
    unique case (state)
      S_IDLE:   cmd.in_rdy = 1'b1;
      S_QMUL:   cmd.q_mul = 1'b1;
      S_QACC:   cmd.q_wr = 1'b1;
      S_RMUL:   cmd.r_mul = 1'b1;
      S_RACC:   cmd.r_acc = 1'b1;
      S_AXIS:   cmd.div_start = !sts.d_zero;
      S_DIV0: begin
        cmd.t0_wr     = sts.div_done;
        cmd.div_start = sts.div_done;
        cmd.div_hi    = 1'b1;
      end
      S_DIV1:   cmd.t1_wr = sts.div_done;
      S_SLAB:   cmd.slab_upd = 1'b1;
      S_HMUL:   cmd.h_mul = 1'b1;
      S_HACC:   cmd.h_wr = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_FINISH: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      j     <= '0;
      r     <= '0;
      axis  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          k    <= '0;
          j    <= '0;
          r    <= '0;
          axis <= '0;
          if (sts.in_acc) begin
            if (sts.in_movable) state <= S_QMUL;
            else if (sts.in_last) state <= S_FINISH;
          end
        end
        S_QMUL: state <= S_QACC;
        S_QACC: begin
          if (k == 4'd8) state <= S_RMUL;
          else begin
            k     <= k + 4'd1;
            state <= S_QMUL;
          end
        end
        S_RMUL: state <= S_RACC;
        S_RACC: begin
          if (r == 2'd2) begin
            r <= '0;
            if (j == 3'd5) state <= S_AXIS;
            else begin
              j     <= j + 3'd1;
              state <= S_RMUL;
            end
          end else begin
            r     <= r + 2'd1;
            state <= S_RMUL;
          end
        end
        S_AXIS: begin
          if (!sts.d_zero) state <= S_DIV0;
          else if (sts.par_miss) state <= S_ENDQ;
          else if (axis == 2'd2) begin
            axis  <= '0;
            state <= S_DECIDE;
          end else axis <= axis + 2'd1;
        end
        S_DIV0: if (sts.div_done) state <= S_DIV1;
        S_DIV1: if (sts.div_done) state <= S_SLAB;
        S_SLAB: begin
          if (sts.slab_miss) state <= S_ENDQ;
          else if (axis == 2'd2) begin
            axis  <= '0;
            state <= S_DECIDE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_AXIS;
          end
        end
        S_DECIDE: state <= sts.better ? S_HMUL : S_ENDQ;
        S_HMUL:   state <= S_HACC;
        S_HACC: begin
          if (axis == 2'd2) state <= S_COMMIT;
          else begin
            axis  <= axis + 2'd1;
            state <= S_HMUL;
          end
        end
        S_COMMIT: state <= S_ENDQ;
        S_ENDQ:   state <= sts.last ? S_FINISH : S_IDLE;
        S_FINISH: if (sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/ray_oriented_box_pick.sv =====
// Ray pick against a stream of oriented boxes, nearest hit wins.
// cfg_ch: register writes (index 0..2 ray origin, 3..5 ray direction, Q16.16);
//   always ready, unknown indexes are dropped. Write only while the block is idle.
// in_ch: one body per request: center, orientation quaternion, full size,
//   movable and last_body flags. Bodies with movable low only take an index.
// out_ch: one result per query, issued after the request flagged last_body:
//   hit flag, arrival index, ray parameter and box-local hit point.
// Flow: one body in flight at a time. A movable body runs its multiply work
//   (9 quaternion products, 18 rotation products, 3 hit-point products, each
//   a multiply step and an accumulate step through the one shared multiplier)
//   and its slab divisions, two divisions per non-parallel axis; the 48-step
//   bit-serial divider sets most of its run time.
// Result: after the last body the sequencer enters S_FINISH and loads the output register once it is free.
// Stall: the result sits in the output register; the next query runs on
//   while it waits, and only its final body holds until the register frees.
// Reset (rst, synchronous): clears the ray to zero, the nearest-hit state to
//   "no hit" at the saturated distance, and the body counter.
module ray_oriented_box_pick #(
  parameter int MAX_BODIES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  rop_in_if.sink    in_ch,
  rop_out_if.source out_ch,
  rop_cfg_if.sink   cfg_ch
);
  import rop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks products, divisions and slab updates
  rop_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // datapath: config, item, shared multiplier, divider, best-hit registers
  rop_dp #(
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );
endmodule

// ===== verif/tb_pkg.sv =====
package tb_pkg;

  import rop_pkg::*;

  // one body request
  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [17:0] rot_x, rot_y, rot_z, rot_w;
    logic [30:0]        size [3];
    logic               movable;
    logic               last_body;
  } body_t;

  // one pick result
  typedef struct {
    logic               hit;
    logic [9:0]         body_index;
    logic [30:0]        hit_distance;
    logic signed [31:0] loc [3];
  } pick_t;

endpackage

// ===== verif/tb_ifs.sv =====
// No extra interfaces needed; the channel interfaces come with the RTL.
package tb_ifs_pkg;
  localparam int RESULT_LATENCY = 4;
endpackage

// ===== verif/tb_top.sv =====
module tb_top;

  import rop_pkg::*;
  import tb_pkg::*;
  import tb_ifs_pkg::*;

  localparam longint T_INF64 = 64'sd2147483647;
  localparam longint T_MIN64 = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rop_in_if  in_ch ();
  rop_out_if out_ch ();
  rop_cfg_if cfg_ch ();

  ray_oriented_box_pick dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor state: ray registers plus the running nearest hit.
  // ---------------------------------------------------------------
  longint ray [6];
  longint near_dist;
  logic [9:0] near_body;
  longint near_loc [3];
  logic near_any;
  logic [9:0] arrival;

  pick_t picks_due [$];
  int errors = 0;
  longint cycles = 0;
  bit stall_on = 1'b1;

  function automatic longint rnd_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > T_INF64) return T_INF64;
    if (v < T_MIN64) return T_MIN64;
    return v;
  endfunction

  function automatic void clear_pick();
    near_dist = T_INF64;
    near_body = '0;
    near_loc = '{0, 0, 0};
    near_any = 1'b0;
    arrival = '0;
  endfunction

  // Carry one accepted body through the pick rules; queue a result on last.
  function automatic void pick_body(body_t b);
    longint qx, qy, qz, qw;
    longint m [3][3];
    longint rel [3], dir [3], o [3], d [3], half [3];
    longint t_in, t_out, t0, t1, sw, th, acc;
    bit hit;
    pick_t p;
    if (b.movable) begin
      qx = b.rot_x; qy = b.rot_y; qz = b.rot_z; qw = b.rot_w;
      m[0][0] = rnd_q16((64'sd1 <<< 32) - 2 * (qy*qy + qz*qz));
      m[0][1] = rnd_q16(2 * (qx*qy - qz*qw));
      m[0][2] = rnd_q16(2 * (qx*qz + qy*qw));
      m[1][0] = rnd_q16(2 * (qx*qy + qz*qw));
      m[1][1] = rnd_q16((64'sd1 <<< 32) - 2 * (qx*qx + qz*qz));
      m[1][2] = rnd_q16(2 * (qy*qz - qx*qw));
      m[2][0] = rnd_q16(2 * (qx*qz - qy*qw));
      m[2][1] = rnd_q16(2 * (qy*qz + qx*qw));
      m[2][2] = rnd_q16((64'sd1 <<< 32) - 2 * (qx*qx + qy*qy));
      for (int i = 0; i < 3; i++) begin
        rel[i] = ray[i] - longint'(b.pos[i]);
        dir[i] = ray[3+i];
        half[i] = longint'(b.size[i] >> 1);
      end
      // conjugate rotation = transposed matrix
      for (int i = 0; i < 3; i++) begin
        acc = m[0][i]*rel[0] + m[1][i]*rel[1] + m[2][i]*rel[2];
        o[i] = clamp32(rnd_q16(acc));
        acc = m[0][i]*dir[0] + m[1][i]*dir[1] + m[2][i]*dir[2];
        d[i] = clamp32(rnd_q16(acc));
      end
      t_in = 0; t_out = T_INF64; hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (!hit) continue;
        if (d[i] == 0) begin
          // parallel axis: origin must lie inside the slab
          if (o[i] < -half[i] || o[i] > half[i]) hit = 1'b0;
          continue;
        end
        t0 = clamp32(((-half[i] - o[i]) * 65536) / d[i]);
        t1 = clamp32(((half[i] - o[i]) * 65536) / d[i]);
        if (t0 > t1) begin sw = t0; t0 = t1; t1 = sw; end
        if (t0 > t_in) t_in = t0;
        if (t1 < t_out) t_out = t1;
        if (t_in > t_out) hit = 1'b0;
      end
      th = (t_in >= 0) ? t_in : t_out;
      if (hit && th >= 0 && th < near_dist) begin
        near_dist = th;
        near_body = arrival;
        near_any = 1'b1;
        for (int i = 0; i < 3; i++) near_loc[i] = clamp32(o[i] + rnd_q16(d[i] * th));
      end
    end
    arrival = arrival + 10'd1;
    if (b.last_body) begin
      p.hit = near_any;
      p.body_index = near_body;
      p.hit_distance = near_dist[30:0];
      for (int i = 0; i < 3; i++) p.loc[i] = near_loc[i][31:0];
      picks_due.insert(picks_due.size(), p);
      clear_pick();
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // ---------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------
  task automatic idle_gap();
    if (stall_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Send one body request and run it through the predictor when taken.
  // valid stays up after the handshake; the next request, an idle gap or
  // wait_idle takes it over.
  task automatic send_body(body_t b);
    idle_gap();
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= b.pos[0]; in_ch.pos_y <= b.pos[1]; in_ch.pos_z <= b.pos[2];
    in_ch.rot_x <= b.rot_x; in_ch.rot_y <= b.rot_y;
    in_ch.rot_z <= b.rot_z; in_ch.rot_w <= b.rot_w;
    in_ch.size_x <= b.size[0]; in_ch.size_y <= b.size[1]; in_ch.size_z <= b.size[2];
    in_ch.movable <= b.movable;
    in_ch.last_body <= b.last_body;
    do @(posedge clk); while (!in_ch.ready);
    pick_body(b);
  endtask

  // cfg valid stays up after the write; the caller drops it after the last one
  task automatic write_reg(logic [2:0] idx, longint v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v[31:0];
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < 3'd6) ray[idx] = longint'(signed'(v[31:0]));
  endtask

  // Drain all results, then let the block settle before touching registers.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 400) @(posedge clk);
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy); write_reg(REG_DIR_Z, dz);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------
  // Result side: random stalls, one compare per accepted result
  // ---------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pick_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (picks_due.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = picks_due.pop_front();
        if (out_ch.hit !== w.hit) report("hit", out_ch.hit, w.hit);
        if (out_ch.body_index !== w.body_index)
          report("body_index", out_ch.body_index, w.body_index);
        if (out_ch.hit_distance !== w.hit_distance)
          report("hit_distance", out_ch.hit_distance, w.hit_distance);
        if (out_ch.local_x !== w.loc[0]) report("local_x", out_ch.local_x, w.loc[0]);
        if (out_ch.local_y !== w.loc[1]) report("local_y", out_ch.local_y, w.loc[1]);
        if (out_ch.local_z !== w.loc[2]) report("local_z", out_ch.local_z, w.loc[2]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic signed [17:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'sd0;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic longint rand_q(int span);
    return longint'($signed($urandom_range(0, 2 * span))) - span;
  endfunction

  // Mostly boxes near the ray and unit-ish quaternions; some wild values.
  function automatic body_t rand_body(bit last);
    body_t b;
    bit wild;
    wild = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = wild ? 32'($urandom) : 32'(rand_q(20 << 16));
      b.size[i] = wild ? 31'($urandom) : 31'($urandom_range(0, 8 << 16));
    end
    b.rot_x = rand_rot(); b.rot_y = rand_rot(); b.rot_z = rand_rot(); b.rot_w = rand_rot();
    if (!wild && $urandom_range(0, 1)) begin
      b.rot_x = '0; b.rot_y = '0; b.rot_z = '0; b.rot_w = 18'sd65536;
      if ($urandom_range(0, 1)) begin
        b.rot_z = 18'sd46341; b.rot_w = 18'sd46341;
      end
    end
    b.movable = ($urandom_range(0, 5) != 0);
    b.last_body = last;
    return b;
  endfunction

  function automatic body_t plain_box(longint px, longint py, longint pz, longint sz,
                                      bit last);
    body_t b;
    b.pos = '{32'(px), 32'(py), 32'(pz)};
    b.size = '{31'(sz), 31'(sz), 31'(sz)};
    b.rot_x = '0; b.rot_y = '0; b.rot_z = '0; b.rot_w = 18'sd65536;
    b.movable = 1'b1;
    b.last_body = last;
    return b;
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_axis_ray();
    body_t b;
    set_ray(0, 0, -(10 << 16), 0, 0, 1 << 16);
    send_body(plain_box(0, 0, 0, 2 << 16, 1'b1));          // straight hit
    send_body(plain_box(5 << 16, 0, 0, 2 << 16, 1'b1));    // parallel miss
    b = plain_box(0, 0, 0, 2 << 16, 1'b0); b.movable = 1'b0;
    send_body(b);                                          // skipped body
    send_body(plain_box(0, 0, 4 << 16, 2 << 16, 1'b0));
    send_body(plain_box(0, 0, 4 << 16, 2 << 16, 1'b0));    // tie keeps earlier
    send_body(plain_box(0, 0, 0, 2 << 16, 1'b1));          // nearer wins
    send_body(plain_box(0, 0, -(10 << 16), 4 << 16, 1'b1)); // origin inside
    send_body(plain_box(0, 0, -(20 << 16), 2 << 16, 1'b1)); // behind the ray
  endtask

  task automatic test_extremes();
    body_t b;
    set_ray(64'sh7FFFFFFF, -64'sh80000000, 0, -64'sh80000000, 64'sh7FFFFFFF, 1);
    b.pos = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    b.size = '{31'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF};
    b.rot_x = -18'sd65536; b.rot_y = 18'sd65536; b.rot_z = -18'sd65536; b.rot_w = 18'sd65536;
    b.movable = 1'b1; b.last_body = 1'b1;
    send_body(b);
    b.rot_x = 18'sh1FFFF; b.rot_y = 18'sh20000; b.rot_z = '0; b.rot_w = '0;
    b.size = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    send_body(b);
    b.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    b.rot_w = -18'sd65536;
    send_body(b);
    // zero ray direction: every axis parallel
    set_ray(1 << 16, 0, 0, 0, 0, 0);
    send_body(plain_box(0, 0, 0, 4 << 16, 1'b1));
    send_body(plain_box(0, 0, 0, 1 << 16, 1'b1));
    wait_idle();
    write_reg(REG_NONE, -1);   // dropped index
    cfg_ch.valid <= 1'b0;
    send_body(plain_box(0, 0, 0, 4 << 16, 1'b1));
  endtask

  // Long query so the arrival index wraps around past 1023.
  task automatic test_index_wrap();
    set_ray(0, 0, -(50 << 16), 0, 0, 1 << 16);
    for (int n = 0; n < 1030; n++) begin
      body_t b;
      b = plain_box(0, 0, 0, 2 << 16, n == 1029);
      b.movable = (n == 1026);
      send_body(b);
    end
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 90 == 0)
        set_ray(rand_q(30 << 16), rand_q(30 << 16), rand_q(30 << 16),
                rand_q(2 << 16), rand_q(2 << 16),
                $urandom_range(0, 3) == 0 ? 0 : rand_q(2 << 16));
      if (n == count / 2) wait_idle();   // sender holds until all results are in
      if (n > count - 120) stall_on = 1'b0;
      send_body(rand_body($urandom_range(0, 5) == 0));
    end
    send_body(rand_body(1'b1));
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.rot_x = '0; in_ch.rot_y = '0; in_ch.rot_z = '0; in_ch.rot_w = '0;
    in_ch.size_x = '0; in_ch.size_y = '0; in_ch.size_z = '0;
    in_ch.movable = 1'b0; in_ch.last_body = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    ray = '{0, 0, 0, 0, 0, 0};
    clear_pick();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axis_ray();
    test_extremes();
    test_index_wrap();
    test_random(400);
    wait_idle();
    if (errors == 0 && picks_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rop_pkg.sv
rtl/rop_in_if.sv
rtl/rop_out_if.sv
rtl/rop_cfg_if.sv
rtl/rop_div.sv
rtl/rop_dp.sv
rtl/rop_ctrl.sv
rtl/ray_oriented_box_pick.sv
verif/tb_pkg.sv
verif/tb_ifs.sv
verif/tb_top.sv
